// ===== design/lexer_token_scanner_top_assert.svh =====
// assertion helpers shared by the scanner modules
`ifndef LEXER_TOKEN_SCANNER_TOP_ASSERT_SVH
`define LEXER_TOKEN_SCANNER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LEXTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer scanner check failed");

// next-cycle implication, checked outside reset
`define LEXTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer scanner check failed");

`endif

// ===== design/lexts_pkg.sv =====
package lexts_pkg;

  localparam int unsigned MAX_TOKEN_LENGTH = 255;
  localparam int unsigned LINE_BITS = 24;

  localparam logic [7:0] LenCap = (MAX_TOKEN_LENGTH < 255) ? 8'(MAX_TOKEN_LENGTH) : 8'd255;
  localparam logic [23:0] LineCap = (LINE_BITS >= 24) ? 24'hFFFFFF :
                                    24'((64'd1 << LINE_BITS) - 64'd1);

  localparam int unsigned QDepth = 3;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_BANG,
    MODE_EQ,
    MODE_GT,
    MODE_LT,
    MODE_STR,
    MODE_NUM,
    MODE_NUMDOT,
    MODE_IDENT
  } mode_e;

  // token kinds
  localparam logic [4:0] KindLParen  = 5'd0;
  localparam logic [4:0] KindRParen  = 5'd1;
  localparam logic [4:0] KindLBrace  = 5'd2;
  localparam logic [4:0] KindRBrace  = 5'd3;
  localparam logic [4:0] KindPlus    = 5'd4;
  localparam logic [4:0] KindMinus   = 5'd5;
  localparam logic [4:0] KindStar    = 5'd6;
  localparam logic [4:0] KindSlash   = 5'd7;
  localparam logic [4:0] KindBang    = 5'd8;
  localparam logic [4:0] KindAssign  = 5'd10;
  localparam logic [4:0] KindGt      = 5'd12;
  localparam logic [4:0] KindLt      = 5'd14;
  localparam logic [4:0] KindSemi    = 5'd16;
  localparam logic [4:0] KindString  = 5'd17;
  localparam logic [4:0] KindInt     = 5'd18;
  localparam logic [4:0] KindFloat   = 5'd19;
  localparam logic [4:0] KindIdent   = 5'd20;
  localparam logic [4:0] KindUnknown = 5'd21;

  // character codes
  localparam logic [7:0] CharEq     = 8'h3D;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharUnder  = 8'h5F;
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharNl     = 8'h0A;
  localparam logic [7:0] CharBang   = 8'h21;
  localparam logic [7:0] CharGt     = 8'h3E;
  localparam logic [7:0] CharLt     = 8'h3C;
  localparam logic [7:0] CharLParen = 8'h28;
  localparam logic [7:0] CharRParen = 8'h29;
  localparam logic [7:0] CharLBrace = 8'h7B;
  localparam logic [7:0] CharRBrace = 8'h7D;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharSemi   = 8'h3B;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;

  typedef struct packed {
    logic [4:0]  kind;
    logic [23:0] line;
    logic [7:0]  length;
    logic        fraction_missing;
    logic        too_many_dots;
    logic        unclosed_string;
    logic        error_seen;
    logic        last;
  } token_t;

  // tokens produced by one accepted item, first in tok0
  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  // single-character kind of a pending operator
  function automatic logic [4:0] op_single(input mode_e m);
    logic [4:0] k;
    unique case (m)
      MODE_BANG: k = KindBang;
      MODE_EQ:   k = KindAssign;
      MODE_GT:   k = KindGt;
      default:   k = KindLt;
    endcase
    return k;
  endfunction

endpackage

// ===== design/lexts_scan.sv =====
module lexts_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic               eos_i,
  input  logic [7:0]         char_i,
  output lexts_pkg::push_t   push_o
);
  import lexts_pkg::*;

  mode_e       mode_q, mode_d;
  logic [23:0] line_q, line_d;
  logic [7:0]  len_q, len_d;
  logic [1:0]  dots_q, dots_d;
  logic        frac_q, frac_d;
  logic        err_q, err_d;

  logic [7:0]  len_inc;
  logic [23:0] line_inc;
  logic        pend_v;
  logic [4:0]  pend_kind;
  logic [7:0]  pend_len;
  logic        pend_frac;
  logic        pend_many;
  logic        pend_unc;
  logic        start;
  logic        st_v;
  logic [4:0]  st_kind;
  logic        err1;
  logic [4:0]  num_kind;
  token_t      pend_tok;
  token_t      st_tok;

  assign len_inc  = (len_q < LenCap) ? len_q + 8'd1 : len_q;
  assign line_inc = (line_q < LineCap) ? line_q + 24'd1 : line_q;
  assign num_kind = (dots_q == 2'd0) ? KindInt : (dots_q == 2'd1) ? KindFloat : KindUnknown;

  always_comb begin
    mode_d    = mode_q;
    line_d    = line_q;
    len_d     = len_q;
    dots_d    = dots_q;
    frac_d    = frac_q;
    pend_v    = 1'b0;
    pend_kind = KindUnknown;
    pend_len  = 8'd1;
    pend_frac = 1'b0;
    pend_many = 1'b0;
    pend_unc  = 1'b0;
    start     = 1'b0;
    st_v      = 1'b0;
    st_kind   = KindUnknown;

    if (eos_i) begin
      unique case (mode_q)
        MODE_BANG, MODE_EQ, MODE_GT, MODE_LT: begin
          pend_v    = 1'b1;
          pend_kind = op_single(mode_q);
        end
        MODE_STR: begin
          pend_v    = 1'b1;
          pend_kind = KindString;
          pend_len  = len_q;
          pend_unc  = 1'b1;
        end
        MODE_NUM, MODE_NUMDOT: begin
          pend_v    = 1'b1;
          pend_kind = num_kind;
          pend_len  = len_q;
          pend_frac = frac_q | (mode_q == MODE_NUMDOT);
          pend_many = dots_q[1];
          frac_d    = pend_frac;
        end
        MODE_IDENT: begin
          pend_v    = 1'b1;
          pend_kind = KindIdent;
          pend_len  = len_q;
        end
        default: ;
      endcase
      mode_d = MODE_IDLE;
      len_d  = 8'd0;
    end else begin
      unique case (mode_q)
        MODE_BANG, MODE_EQ, MODE_GT, MODE_LT: begin
          pend_v = 1'b1;
          if (char_i == CharEq) begin
            pend_kind = op_single(mode_q) + 5'd1;
            pend_len  = 8'd2;
            mode_d    = MODE_IDLE;
            len_d     = 8'd0;
          end else begin
            pend_kind = op_single(mode_q);
            start     = 1'b1;
          end
        end
        MODE_STR: begin
          len_d = len_inc;
          if (char_i == CharQuote) begin
            pend_v    = 1'b1;
            pend_kind = KindString;
            pend_len  = len_inc;
            mode_d    = MODE_IDLE;
            len_d     = 8'd0;
          end else if (char_i == CharNl) begin
            line_d = line_inc;
          end
        end
        MODE_NUM: begin
          if (char_i == CharDot) begin
            len_d  = len_inc;
            dots_d = dots_q[1] ? dots_q : dots_q + 2'd1;
            mode_d = MODE_NUMDOT;
          end else if (is_digit(char_i)) begin
            len_d = len_inc;
          end else begin
            pend_v    = 1'b1;
            pend_kind = num_kind;
            pend_len  = len_q;
            pend_frac = frac_q;
            pend_many = dots_q[1];
            start     = 1'b1;
          end
        end
        MODE_NUMDOT: begin
          if (is_digit(char_i)) begin
            len_d  = len_inc;
            mode_d = MODE_NUM;
          end else begin
            frac_d    = 1'b1;
            pend_v    = 1'b1;
            pend_kind = num_kind;
            pend_len  = len_q;
            pend_frac = 1'b1;
            pend_many = dots_q[1];
            start     = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_digit(char_i) || is_alpha(char_i) || char_i == CharUnder) begin
            len_d = len_inc;
          end else begin
            pend_v    = 1'b1;
            pend_kind = KindIdent;
            pend_len  = len_q;
            start     = 1'b1;
          end
        end
        default: start = 1'b1;
      endcase

      // the new character opens a token of its own
      if (start) begin
        mode_d = MODE_IDLE;
        len_d  = 8'd1;
        case (char_i)
          CharLParen: begin st_v = 1'b1; st_kind = KindLParen; end
          CharRParen: begin st_v = 1'b1; st_kind = KindRParen; end
          CharLBrace: begin st_v = 1'b1; st_kind = KindLBrace; end
          CharRBrace: begin st_v = 1'b1; st_kind = KindRBrace; end
          CharPlus:   begin st_v = 1'b1; st_kind = KindPlus; end
          CharMinus:  begin st_v = 1'b1; st_kind = KindMinus; end
          CharStar:   begin st_v = 1'b1; st_kind = KindStar; end
          CharSlash:  begin st_v = 1'b1; st_kind = KindSlash; end
          CharSemi:   begin st_v = 1'b1; st_kind = KindSemi; end
          CharBang:   mode_d = MODE_BANG;
          CharEq:     mode_d = MODE_EQ;
          CharGt:     mode_d = MODE_GT;
          CharLt:     mode_d = MODE_LT;
          CharQuote:  mode_d = MODE_STR;
          CharNl: begin
            len_d  = 8'd0;
            line_d = line_inc;
          end
          default: begin
            if (is_space(char_i)) begin
              len_d = 8'd0;
            end else if (is_digit(char_i)) begin
              mode_d = MODE_NUM;
              dots_d = 2'd0;
              frac_d = 1'b0;
            end else if (is_alpha(char_i)) begin
              mode_d = MODE_IDENT;
            end else begin
              st_v    = 1'b1;
              st_kind = KindUnknown;
            end
          end
        endcase
      end
    end

    err1  = err_q | (pend_v & (pend_frac | pend_many | pend_unc));
    err_d = err1;
  end

  always_comb begin
    pend_tok                  = '0;
    pend_tok.kind             = pend_kind;
    pend_tok.line             = line_q;
    pend_tok.length           = pend_len;
    pend_tok.fraction_missing = pend_frac;
    pend_tok.too_many_dots    = pend_many;
    pend_tok.unclosed_string  = pend_unc;
    pend_tok.error_seen       = err1;
    pend_tok.last             = ~st_v;

    st_tok            = '0;
    st_tok.kind       = st_kind;
    st_tok.line       = line_q;
    st_tok.length     = 8'd1;
    st_tok.error_seen = err1;
    st_tok.last       = 1'b1;

    push_o.cnt  = fire_i ? {1'b0, pend_v} + {1'b0, st_v} : 2'd0;
    push_o.tok0 = pend_v ? pend_tok : st_tok;
    push_o.tok1 = st_tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      line_q <= 24'd1;
      len_q  <= 8'd0;
      dots_q <= 2'd0;
      frac_q <= 1'b0;
      err_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      line_q <= line_d;
      len_q  <= len_d;
      dots_q <= dots_d;
      frac_q <= frac_d;
      err_q  <= err_d;
    end
  end

`include "lexer_token_scanner_top_assert.svh"

  `LEXTS_ASSERT_NXT(a_err_sticky, clk_i, rst_ni, err_q, err_q)
  `LEXTS_ASSERT_NXT(a_line_monotonic, clk_i, rst_ni, 1'b1, line_q >= $past(line_q))

endmodule

// ===== design/lexts_outq.sv =====
module lexts_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lexts_pkg::push_t   push_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               pop_ready_i,
  output lexts_pkg::token_t  tok_o
);
  import lexts_pkg::*;

  token_t     entry_q [QDepth];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  function automatic logic [1:0] ptr_next(input logic [1:0] p);
    return (p == 2'(QDepth - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  // room for two tokens whatever the sink does this cycle
  assign ready_o = (count_q <= 2'd1);
  assign valid_o = (count_q != 2'd0);
  assign tok_o   = entry_q[rd_q];
  assign pop     = valid_o & pop_ready_i;

  always_comb begin
    count_d = count_q - {1'b0, pop} + push_i.cnt;
    rd_d    = pop ? ptr_next(rd_q) : rd_q;
    case (push_i.cnt)
      2'd1:    wr_d = ptr_next(wr_q);
      2'd2:    wr_d = ptr_next(ptr_next(wr_q));
      default: wr_d = wr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entry_q[wr_q] <= push_i.tok0;
    end
    if (push_i.cnt == 2'd2) begin
      entry_q[ptr_next(wr_q)] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 2'd0;
      rd_q    <= 2'd0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

`include "lexer_token_scanner_top_assert.svh"

  `LEXTS_ASSERT_IMP(a_push_has_room, clk_i, rst_ni, push_i.cnt != 2'd0, count_q <= 2'd1)
  `LEXTS_ASSERT_IMP(a_ptr_range, clk_i, rst_ni, 1'b1,
                    (wr_q != 2'd3) && (rd_q != 2'd3))
  `LEXTS_ASSERT_NXT(a_pop_drains, clk_i, rst_ni, pop && (push_i.cnt == 2'd0),
                    count_q == $past(count_q) - 2'd1)

endmodule

// ===== design/lexer_token_scanner_top.sv =====
// channel   dir  tdata                                        tuser        tlast
// s_axis    in   [7:0] char_code                              kind (eos)   -
// m_axis    out  [23:0] token_line [31:24] token_length       token_kind   last
//                [32] fraction_missing [33] too_many_dots
//                [34] unclosed_string [35] error_seen, rest 0
//
// one input item per cycle while s_axis_tready_o is high; the scanner state updates in
// the accept cycle and its tokens land in a three-entry token queue, shown from the next cycle;
// an item yielding two tokens writes both queue entries at once: input is taken only
// while at most one token waits in the queue
// reset: idle mode, line 1, counters and error flag clear, queue empty
// output stalls back up through the queue into s_axis_tready_o
module lexer_token_scanner_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // char_code
  input  logic        s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // token_line, token_length, fraction_missing,
                                        // too_many_dots, unclosed_string, error_seen
  output logic [4:0]  m_axis_tuser_o,   // token_kind
  output logic        m_axis_tlast_o
);
  import lexts_pkg::*;

  logic   fire;
  push_t  push;
  token_t tok;

  assign fire = s_axis_tvalid_i & s_axis_tready_o;

  lexts_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .eos_i  (s_axis_tuser_i),
    .char_i (s_axis_tdata_i),
    .push_o (push)
  );

  lexts_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .ready_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .tok_o       (tok)
  );

  assign m_axis_tdata_o = {4'b0000, tok.error_seen, tok.unclosed_string, tok.too_many_dots,
                           tok.fraction_missing, tok.length, tok.line};
  assign m_axis_tuser_o = tok.kind;
  assign m_axis_tlast_o = tok.last;

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lexts_pkg::*;

  localparam logic [7:0] CharVt = 8'h0B;
  localparam logic [7:0] CharFf = 8'h0C;
  localparam int unsigned RandomItems = 1250;

  class token_scoreboard;
    mode_e       mode;
    logic [23:0] line_no;
    logic [7:0]  tok_len;
    logic [1:0]  dots;
    logic        frac_flag;
    logic        err_flag;
    token_t      expected_tokens[$];
    token_t      step_tokens[$];
    int          failures;

    function new();
      mode      = MODE_IDLE;
      line_no   = 24'd1;
      tok_len   = 8'd0;
      dots      = 2'd0;
      frac_flag = 1'b0;
      err_flag  = 1'b0;
      failures  = 0;
    endfunction

    function bit char_is_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    function bit char_is_letter(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function bit char_is_blank(logic [7:0] c);
      return c == CharSpace || (c >= CharTab && c <= CharCr);
    endfunction

    function logic [4:0] single_kind(mode_e m);
      case (m)
        MODE_BANG: return KindBang;
        MODE_EQ:   return KindAssign;
        MODE_GT:   return KindGt;
        default:   return KindLt;
      endcase
    endfunction

    function void bump_line();
      if (line_no < LineCap) line_no++;
    endfunction

    function void bump_len();
      if (tok_len < LenCap) tok_len++;
    endfunction

    function void push_token(logic [4:0] kind, logic [7:0] len, logic frac, logic many,
                             logic unc);
      token_t t;
      if (frac | many | unc) err_flag = 1'b1;
      t.kind             = kind;
      t.line             = line_no;
      t.length           = len;
      t.fraction_missing = frac;
      t.too_many_dots    = many;
      t.unclosed_string  = unc;
      t.error_seen       = err_flag;
      t.last             = 1'b0;
      step_tokens = {step_tokens, t};
    endfunction

    function void push_number();
      logic [4:0] kind;
      kind = (dots == 2'd0) ? KindInt : (dots == 2'd1) ? KindFloat : KindUnknown;
      push_token(kind, tok_len, frac_flag, dots >= 2'd2, 1'b0);
    endfunction

    // first character of a new token, after any pending one was emitted
    function void begin_char(logic [7:0] c);
      mode    = MODE_IDLE;
      tok_len = 8'd1;
      case (c)
        CharLParen: push_token(KindLParen, 8'd1, 1'b0, 1'b0, 1'b0);
        CharRParen: push_token(KindRParen, 8'd1, 1'b0, 1'b0, 1'b0);
        CharLBrace: push_token(KindLBrace, 8'd1, 1'b0, 1'b0, 1'b0);
        CharRBrace: push_token(KindRBrace, 8'd1, 1'b0, 1'b0, 1'b0);
        CharPlus:   push_token(KindPlus, 8'd1, 1'b0, 1'b0, 1'b0);
        CharMinus:  push_token(KindMinus, 8'd1, 1'b0, 1'b0, 1'b0);
        CharStar:   push_token(KindStar, 8'd1, 1'b0, 1'b0, 1'b0);
        CharSlash:  push_token(KindSlash, 8'd1, 1'b0, 1'b0, 1'b0);
        CharSemi:   push_token(KindSemi, 8'd1, 1'b0, 1'b0, 1'b0);
        CharBang:   mode = MODE_BANG;
        CharEq:     mode = MODE_EQ;
        CharGt:     mode = MODE_GT;
        CharLt:     mode = MODE_LT;
        CharQuote:  mode = MODE_STR;
        CharNl: begin
          tok_len = 8'd0;
          bump_line();
        end
        default: begin
          if (char_is_blank(c)) begin
            tok_len = 8'd0;
          end else if (char_is_digit(c)) begin
            mode      = MODE_NUM;
            dots      = 2'd0;
            frac_flag = 1'b0;
          end else if (char_is_letter(c)) begin
            mode = MODE_IDENT;
          end else begin
            push_token(KindUnknown, 8'd1, 1'b0, 1'b0, 1'b0);
          end
        end
      endcase
    endfunction

    function void note_input(logic eos, logic [7:0] c);
      token_t t;
      step_tokens.delete();
      if (eos) begin
        case (mode)
          MODE_BANG, MODE_EQ, MODE_GT, MODE_LT:
            push_token(single_kind(mode), 8'd1, 1'b0, 1'b0, 1'b0);
          MODE_STR: push_token(KindString, tok_len, 1'b0, 1'b0, 1'b1);
          MODE_NUMDOT: begin
            frac_flag = 1'b1;
            push_number();
          end
          MODE_NUM:   push_number();
          MODE_IDENT: push_token(KindIdent, tok_len, 1'b0, 1'b0, 1'b0);
          default: ;
        endcase
        mode    = MODE_IDLE;
        tok_len = 8'd0;
      end else begin
        case (mode)
          MODE_BANG, MODE_EQ, MODE_GT, MODE_LT: begin
            if (c == CharEq) begin
              // two-character operator kinds follow their single form
              push_token(single_kind(mode) + 5'd1, 8'd2, 1'b0, 1'b0, 1'b0);
              mode    = MODE_IDLE;
              tok_len = 8'd0;
            end else begin
              push_token(single_kind(mode), 8'd1, 1'b0, 1'b0, 1'b0);
              begin_char(c);
            end
          end
          MODE_STR: begin
            bump_len();
            if (c == CharQuote) begin
              push_token(KindString, tok_len, 1'b0, 1'b0, 1'b0);
              mode    = MODE_IDLE;
              tok_len = 8'd0;
            end else if (c == CharNl) begin
              bump_line();
            end
          end
          MODE_NUM: begin
            if (c == CharDot) begin
              bump_len();
              if (dots < 2'd2) dots++;
              mode = MODE_NUMDOT;
            end else if (char_is_digit(c)) begin
              bump_len();
            end else begin
              push_number();
              begin_char(c);
            end
          end
          MODE_NUMDOT: begin
            if (char_is_digit(c)) begin
              bump_len();
              mode = MODE_NUM;
            end else begin
              frac_flag = 1'b1;
              push_number();
              begin_char(c);
            end
          end
          MODE_IDENT: begin
            if (char_is_digit(c) || char_is_letter(c) || c == CharUnder) begin
              bump_len();
            end else begin
              push_token(KindIdent, tok_len, 1'b0, 1'b0, 1'b0);
              begin_char(c);
            end
          end
          default: begin_char(c);
        endcase
      end
      if (step_tokens.size() != 0) begin
        t = step_tokens.pop_back();
        t.last = 1'b1;
        step_tokens = {step_tokens, t};
      end
      expected_tokens = {expected_tokens, step_tokens};
    endfunction

    function string token_text(token_t t);
      return $sformatf("kind %0d line %0d len %0d frac %b dots %b unclosed %b err %b last %b",
                       t.kind, t.line, t.length, t.fraction_missing, t.too_many_dots,
                       t.unclosed_string, t.error_seen, t.last);
    endfunction

    function void check_token(token_t got, logic [3:0] pad);
      token_t want;
      if (expected_tokens.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected token: %s", token_text(got));
        return;
      end
      want = expected_tokens.pop_front();
      if (got !== want || pad !== 4'd0) begin
        failures++;
        if (failures <= 10)
          $display("token mismatch: expected %s / got %s pad %h",
                   token_text(want), token_text(got), pad);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'd0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [4:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  token_scoreboard sb;
  token_t          seen_token;
  int unsigned     idle_pct = 0;
  int unsigned     stall_pct = 0;
  int unsigned     items_sent = 0;

  lexer_token_scanner_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      sb.note_input(s_axis_tuser_i, s_axis_tdata_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_token = {m_axis_tuser_o, m_axis_tdata_o[23:0], m_axis_tdata_o[31:24],
                    m_axis_tdata_o[32], m_axis_tdata_o[33], m_axis_tdata_o[34],
                    m_axis_tdata_o[35], m_axis_tlast_o};
      sb.check_token(seen_token, m_axis_tdata_o[39:36]);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic eos, input logic [7:0] code);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= eos;
    s_axis_tdata_i  <= code;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  function automatic logic [7:0] digit_char();
    return 8'(8'h30 + $urandom_range(9));
  endfunction

  function automatic logic [7:0] letter_char();
    return $urandom_range(1) ? 8'(8'h41 + $urandom_range(25)) : 8'(8'h61 + $urandom_range(25));
  endfunction

  function automatic logic [7:0] ident_char();
    case ($urandom_range(5))
      0:       return digit_char();
      1:       return CharUnder;
      default: return letter_char();
    endcase
  endfunction

  function automatic logic [7:0] string_char();
    case ($urandom_range(9))
      0:       return CharNl;
      1:       return 8'($urandom_range(255));
      2:       return CharSpace;
      default: return letter_char();
    endcase
  endfunction

  // one token long enough to hit the length ceiling
  task automatic send_long(input int sel);
    case (sel)
      1: begin
        send_item(1'b0, CharQuote);
        repeat (258) send_item(1'b0, ($urandom_range(15) == 0) ? CharNl : letter_char());
        send_item(1'b0, CharQuote);
      end
      2: begin
        repeat (250) send_item(1'b0, digit_char());
        send_item(1'b0, CharDot);
        repeat (10) send_item(1'b0, digit_char());
      end
      default: begin
        send_item(1'b0, letter_char());
        repeat (260) send_item(1'b0, ident_char());
      end
    endcase
    send_item(1'b0, CharSpace);
  endtask

  task automatic send_lexeme();
    int unsigned pick;
    logic [7:0]  c;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(8))
        0: c = CharLParen;
        1: c = CharRParen;
        2: c = CharLBrace;
        3: c = CharRBrace;
        4: c = CharPlus;
        5: c = CharMinus;
        6: c = CharStar;
        7: c = CharSlash;
        default: c = CharSemi;
      endcase
      send_item(1'b0, c);
    end else if (pick < 20) begin
      case ($urandom_range(3))
        0: c = CharBang;
        1: c = CharEq;
        2: c = CharGt;
        default: c = CharLt;
      endcase
      send_item(1'b0, c);
      if ($urandom_range(1) != 0) send_item(1'b0, CharEq);
    end else if (pick < 30) begin
      send_item(1'b0, CharQuote);
      repeat ($urandom_range(8)) send_item(1'b0, string_char());
      if ($urandom_range(9) != 0) send_item(1'b0, CharQuote);
    end else if (pick < 45) begin
      send_item(1'b0, digit_char());
      repeat ($urandom_range(5))
        send_item(1'b0, ($urandom_range(3) == 0) ? CharDot : digit_char());
    end else if (pick < 58) begin
      send_item(1'b0, letter_char());
      repeat ($urandom_range(6)) send_item(1'b0, ident_char());
    end else if (pick < 72) begin
      case ($urandom_range(5))
        0: c = CharTab;
        1: c = CharNl;
        2: c = CharCr;
        3: c = CharVt;
        4: c = CharFf;
        default: c = CharSpace;
      endcase
      send_item(1'b0, c);
    end else if (pick < 78) begin
      send_item(1'b1, 8'($urandom_range(255)));
    end else begin
      send_item(1'b0, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int unsigned phase_end;
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // every operator but ==, number with too many dots, two tokens from one item,
    // unclosed string and missing fraction at end of stream
    send_text("(){}+-*/;<>!==>=<=9.1.2a_");
    send_item(1'b0, 8'hFF);
    send_text("\"\n");
    send_item(1'b1, 8'h5A);
    send_text("4.");
    send_item(1'b1, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      // long tokens count toward the phase budget
      phase_end = items_sent + RandomItems / 4;
      if (ph < 3) send_long(ph);
      while (items_sent < phase_end) send_lexeme();
    end
    send_item(1'b1, 8'h00);
    s_axis_tvalid_i <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== lexer_token_scanner_top.f =====
+incdir+design
design/lexts_pkg.sv
design/lexts_scan.sv
design/lexts_outq.sv
design/lexer_token_scanner_top.sv
verif/tb.sv
